FILE: rtl/tabulation_byte_hash64_macros.svh
// ----------------------------------------------------------------------------
// tabulation_byte_hash64 assertion macros
// shared property shorthands for the hash block checks
// ----------------------------------------------------------------------------
`ifndef TABULATION_BYTE_HASH64_MACROS_SVH
`define TABULATION_BYTE_HASH64_MACROS_SVH

// same-cycle implication, checked outside reset
`define TBH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define TBH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/tbh64_pkg.sv
// ----------------------------------------------------------------------------
// tbh64_pkg
// types, codes and constant tables of the tabulation byte hash
// ----------------------------------------------------------------------------
package tbh64_pkg;

    localparam int TDATA_W = 120;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_BYTE  = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    localparam logic [63:0] PRIME_A = 64'hc0f9edd07d89152f;
    localparam logic [63:0] PRIME_B = 64'hace809255f57529b;
    localparam logic [63:0] PRIME_C = 64'hbb83cd5dd6f450b9;

    localparam logic [5:0] MIX_FIRST = 6'd0;
    localparam logic [5:0] MIX_LAST  = 6'd7;
    localparam logic [5:0] FIN_FIRST = 6'd8;
    localparam logic [5:0] FIN_LAST  = 6'd34;

    typedef enum logic [1:0] {
        PR_A,
        PR_B,
        PR_C
    } prime_t;

    typedef enum logic [1:0] {
        LN_A,
        LN_B,
        LN_C
    } lane_t;

    typedef enum logic [2:0] {
        MU_ROT,
        MU_ADD,
        MU_SUB,
        MU_XOR,
        MU_NOT
    } mu_kind_t;

    typedef struct packed {
        lane_t      dst;
        lane_t      src;
        mu_kind_t   kind;
        logic [5:0] rot;
    } micro_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_RD_0,
        OP_RD_1,
        OP_RD_2,
        OP_RD_POS,
        OP_V_EMPTY,
        OP_V_INC,
        OP_V_SEED,
        OP_XS_PRE,
        OP_MUL_LL,
        OP_MUL_LH,
        OP_MUL_HL,
        OP_XS_POST,
        OP_C_FROM_V,
        OP_XOR_POS,
        OP_V_C_LEN1,
        OP_V_C_LEN3,
        OP_V_T1,
        OP_B_FROM_V,
        OP_A_FROM_RD,
        OP_GATHER,
        OP_MICRO,
        OP_TAIL,
        OP_OUT_V,
        OP_OUT_FIN
    } dp_op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_E_RD,
        ST_E_LOAD,
        ST_E_INC,
        ST_S_RD,
        ST_S_LOAD,
        ST_S_SET,
        ST_P_RD,
        ST_P_XOR,
        ST_P_FIN,
        ST_P_DONE,
        ST_T1_RD,
        ST_T1_LOAD,
        ST_B_SET,
        ST_C3,
        ST_C_SET,
        ST_T2_RD,
        ST_A_SET,
        ST_GATHER,
        ST_MIX,
        ST_TAIL_CHK,
        ST_TAIL,
        ST_FIN,
        ST_OUT_V,
        ST_OUT_F,
        ST_XS_PRE,
        ST_MUL_LL,
        ST_MUL_LH,
        ST_MUL_HL,
        ST_XS_POST
    } state_t;

    typedef struct packed {
        dp_op_t     op;
        prime_t     prime;
        logic [5:0] upc;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       len_zero;
        logic       bs_zero;
        logic       bs_lt_tp;
        logic       pos_end;
        logic       bs_ge_len;
        logic       pair_done;
        logic       out_busy;
    } status_t;

    function automatic logic [63:0] rotl64(input logic [63:0] x, input logic [5:0] r);
        return (x << r) | (x >> (7'd64 - {1'b0, r}));
    endfunction

    function automatic logic [63:0] prime_of(input prime_t p);
        case (p)
            PR_A:    return PRIME_A;
            PR_B:    return PRIME_B;
            PR_C:    return PRIME_C;
            default: return PRIME_A;
        endcase
    endfunction

    function automatic logic [63:0] xs_pre(input logic [63:0] x);
        logic [63:0] v;
        v = x ^ (x >> 13);
        v = v ^ (v << 35);
        v = v ^ (v >> 30);
        return v;
    endfunction

    function automatic logic [63:0] xs_post(input logic [63:0] x);
        logic [63:0] v;
        v = x ^ (x >> 19);
        v = v ^ (v << 15);
        v = v ^ (v >> 46);
        return v;
    endfunction

    // lane program: mix rounds first, then the finalize chain
    function automatic micro_t micro_rom(input logic [5:0] idx);
        case (idx)
            6'd0:    return '{LN_A, LN_B, MU_ADD, 6'd8};
            6'd1:    return '{LN_B, LN_C, MU_XOR, 6'd23};
            6'd2:    return '{LN_C, LN_A, MU_XOR, 6'd53};
            6'd3:    return '{LN_A, LN_C, MU_SUB, 6'd16};
            6'd4:    return '{LN_C, LN_B, MU_ADD, 6'd17};
            6'd5:    return '{LN_B, LN_A, MU_SUB, 6'd29};
            6'd6:    return '{LN_A, LN_C, MU_XOR, 6'd29};
            6'd7:    return '{LN_C, LN_A, MU_ADD, 6'd15};
            6'd8:    return '{LN_A, LN_C, MU_SUB, 6'd3};
            6'd9:    return '{LN_C, LN_B, MU_XOR, 6'd0};
            6'd10:   return '{LN_C, LN_A, MU_SUB, 6'd8};
            6'd11:   return '{LN_B, LN_C, MU_SUB, 6'd0};
            6'd12:   return '{LN_A, LN_C, MU_SUB, 6'd41};
            6'd13:   return '{LN_B, LN_B, MU_ROT, 6'd11};
            6'd14:   return '{LN_A, LN_B, MU_SUB, 6'd0};
            6'd15:   return '{LN_B, LN_B, MU_ROT, 6'd11};
            6'd16:   return '{LN_A, LN_B, MU_SUB, 6'd0};
            6'd17:   return '{LN_A, LN_A, MU_ROT, 6'd32};
            6'd18:   return '{LN_C, LN_A, MU_SUB, 6'd57};
            6'd19:   return '{LN_B, LN_A, MU_ADD, 6'd3};
            6'd20:   return '{LN_C, LN_C, MU_ROT, 6'd9};
            6'd21:   return '{LN_B, LN_C, MU_SUB, 6'd0};
            6'd22:   return '{LN_B, LN_B, MU_ROT, 6'd45};
            6'd23:   return '{LN_C, LN_B, MU_XOR, 6'd0};
            6'd24:   return '{LN_B, LN_A, MU_SUB, 6'd0};
            6'd25:   return '{LN_C, LN_C, MU_ROT, 6'd24};
            6'd26:   return '{LN_B, LN_C, MU_XOR, 6'd0};
            6'd27:   return '{LN_B, LN_C, MU_SUB, 6'd47};
            6'd28:   return '{LN_A, LN_B, MU_XOR, 6'd15};
            6'd29:   return '{LN_A, LN_A, MU_ROT, 6'd57};
            6'd30:   return '{LN_B, LN_A, MU_XOR, 6'd0};
            6'd31:   return '{LN_B, LN_B, MU_ROT, 6'd25};
            6'd32:   return '{LN_C, LN_B, MU_SUB, 6'd0};
            6'd33:   return '{LN_C, LN_C, MU_ROT, 6'd27};
            6'd34:   return '{LN_B, LN_B, MU_NOT, 6'd0};
            default: return '{LN_A, LN_A, MU_ROT, 6'd0};
        endcase
    endfunction

endpackage

FILE: rtl/tbh64_datapath.sv
// ----------------------------------------------------------------------------
// tbh64_datapath
// table memory, lanes, scramble multiplier and output register
// ----------------------------------------------------------------------------
module tbh64_datapath
    import tbh64_pkg::*;
#(
    parameter int TAB_POSITIONS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output status_t            status,
    input  logic [TDATA_W-1:0] in_data,
    input  logic [1:0]         in_kind,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [63:0]        out_hash
);

    localparam int DEPTH  = 256 * TAB_POSITIONS + 3;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [63:0] table_mem [DEPTH];

    logic [13:0] in_index;
    logic [63:0] in_word;
    logic [7:0]  in_byte;
    logic [31:0] in_len;

    logic [1:0]  kind_reg;
    logic [7:0]  byte_reg;
    logic [31:0] len_reg;
    logic [63:0] rdata_reg;
    logic [63:0] v_reg;
    logic [63:0] acc_reg;
    logic [63:0] lane_a_reg, lane_b_reg, lane_c_reg;
    logic [31:0] bytes_seen_reg;
    logic [63:0] word_gather_reg, pending_word_reg;
    logic        out_valid_reg;
    logic [63:0] hash_reg;

    logic [ADDR_W-1:0] rd_addr;
    logic              rd_en;
    logic [31:0]       pos_sum;
    logic [32:0]       cnt;
    logic [31:0]       pdiff;
    logic [63:0]       len1, len2, len3;
    logic [63:0]       prime;
    logic [31:0]       mul_x, mul_y;
    logic [63:0]       prod;
    logic [63:0]       gather_new;
    micro_t            mu;
    logic [63:0]       mu_dst, mu_src, mu_rot, mu_res;
    logic              out_load;

    assign in_index = in_data[13:0];
    assign in_word  = in_data[77:14];
    assign in_byte  = in_data[85:78];
    assign in_len   = in_data[117:86];

    assign len1 = {32'd0, len_reg} + 64'd1;
    assign len2 = {32'd0, len_reg} + 64'd2;
    assign len3 = {32'd0, len_reg} + 64'd3;

    assign cnt   = {1'b0, bytes_seen_reg} + 33'd1;
    assign pdiff = bytes_seen_reg - 32'(TAB_POSITIONS);
    assign pos_sum = 32'd3 + (bytes_seen_reg << 8) + {24'd0, byte_reg};

    always_comb
    begin
        rd_en   = 1'b1;
        rd_addr = '0;
        case (cmd.op)
            OP_RD_0:   rd_addr = ADDR_W'(0);
            OP_RD_1:   rd_addr = ADDR_W'(1);
            OP_RD_2:   rd_addr = ADDR_W'(2);
            OP_RD_POS: rd_addr = pos_sum[ADDR_W-1:0];
            default:   rd_en = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LATCH && in_kind == KIND_WRITE && 32'(in_index) < 32'(DEPTH))
        begin
            table_mem[in_index[ADDR_W-1:0]] <= in_word;
        end
        if (rd_en)
        begin
            rdata_reg <= table_mem[rd_addr];
        end
    end

    // 64x64 low product built from three 32x32 partial products
    assign prime = prime_of(cmd.prime);
    always_comb
    begin
        mul_x = v_reg[31:0];
        mul_y = prime[31:0];
        case (cmd.op)
            OP_MUL_LH: mul_y = prime[63:32];
            OP_MUL_HL: mul_x = v_reg[63:32];
            default:   mul_y = prime[31:0];
        endcase
    end
    assign prod = mul_x * mul_y;

    // byte lane insert into the little-endian word
    assign gather_new = word_gather_reg | ({56'd0, byte_reg} << {pdiff[2:0], 3'b000});

    assign mu = micro_rom(cmd.upc);
    always_comb
    begin
        case (mu.dst)
            LN_B:    mu_dst = lane_b_reg;
            LN_C:    mu_dst = lane_c_reg;
            default: mu_dst = lane_a_reg;
        endcase
        case (mu.src)
            LN_B:    mu_src = lane_b_reg;
            LN_C:    mu_src = lane_c_reg;
            default: mu_src = lane_a_reg;
        endcase
        mu_rot = rotl64(mu_dst, mu.rot);
        case (mu.kind)
            MU_ADD:  mu_res = mu_rot + mu_src;
            MU_SUB:  mu_res = mu_rot - mu_src;
            MU_XOR:  mu_res = mu_rot ^ mu_src;
            MU_NOT:  mu_res = ~mu_rot;
            default: mu_res = mu_rot;
        endcase
    end

    assign out_load = (cmd.op == OP_OUT_V) || (cmd.op == OP_OUT_FIN);

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LATCH:
            begin
                kind_reg <= in_kind;
                byte_reg <= in_byte;
                len_reg  <= in_len;
            end
            OP_V_EMPTY:  v_reg <= rdata_reg + 64'd2;
            OP_V_INC:    v_reg <= v_reg + 64'd1;
            OP_V_SEED:   v_reg <= rdata_reg + len1 + len1;
            OP_XS_PRE:   v_reg <= xs_pre(v_reg);
            OP_MUL_LL:   acc_reg <= prod;
            OP_MUL_LH:   acc_reg <= acc_reg + {prod[31:0], 32'd0};
            OP_MUL_HL:   v_reg <= acc_reg + {prod[31:0], 32'd0};
            OP_XS_POST:  v_reg <= xs_post(v_reg);
            OP_V_C_LEN1: v_reg <= lane_c_reg + len1;
            OP_V_C_LEN3: v_reg <= lane_c_reg + len3;
            OP_V_T1:     v_reg <= rdata_reg + len2;
            OP_OUT_V:    hash_reg <= v_reg;
            OP_OUT_FIN:  hash_reg <= lane_a_reg ^ lane_b_reg ^ lane_c_reg;
            default:     v_reg <= v_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_a_reg       <= '0;
            lane_b_reg       <= '0;
            lane_c_reg       <= '0;
            bytes_seen_reg   <= '0;
            word_gather_reg  <= '0;
            pending_word_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (cmd.op)
                OP_C_FROM_V:  lane_c_reg <= v_reg;
                OP_B_FROM_V:  lane_b_reg <= v_reg;
                OP_A_FROM_RD: lane_a_reg <= rdata_reg;
                OP_XOR_POS:
                begin
                    lane_c_reg     <= lane_c_reg ^ rdata_reg;
                    bytes_seen_reg <= cnt[31:0];
                end
                OP_GATHER:
                begin
                    bytes_seen_reg <= cnt[31:0];
                    if (pdiff[2:0] == 3'd7)
                    begin
                        word_gather_reg <= '0;
                        if (!pdiff[3])
                        begin
                            pending_word_reg <= gather_new;
                        end
                        else
                        begin
                            lane_b_reg       <= lane_b_reg - pending_word_reg;
                            lane_a_reg       <= lane_a_reg + gather_new;
                            pending_word_reg <= '0;
                        end
                    end
                    else
                    begin
                        word_gather_reg <= gather_new;
                    end
                end
                OP_MICRO:
                begin
                    case (mu.dst)
                        LN_B:    lane_b_reg <= mu_res;
                        LN_C:    lane_c_reg <= mu_res;
                        default: lane_a_reg <= mu_res;
                    endcase
                end
                // length-tagged tail, bytes_seen already holds the full count
                OP_TAIL:
                begin
                    if (pdiff[3])
                    begin
                        lane_b_reg <= lane_b_reg - pending_word_reg;
                    end
                    lane_a_reg <= lane_a_reg + {len1[7:0], 56'd0}
                                  + ((pdiff[2:0] != 3'd0) ? word_gather_reg : 64'd0);
                    if (pdiff[2:0] == 3'd0)
                    begin
                        lane_c_reg <= lane_c_reg ^ 64'h00000000000000FF;
                    end
                end
                OP_OUT_V, OP_OUT_FIN:
                begin
                    lane_a_reg       <= '0;
                    lane_b_reg       <= '0;
                    lane_c_reg       <= '0;
                    bytes_seen_reg   <= '0;
                    word_gather_reg  <= '0;
                    pending_word_reg <= '0;
                end
                default:
                begin
                    bytes_seen_reg <= bytes_seen_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        status.kind      = kind_reg;
        status.len_zero  = (len_reg == 32'd0);
        status.bs_zero   = (bytes_seen_reg == 32'd0);
        status.bs_lt_tp  = (bytes_seen_reg < 32'(TAB_POSITIONS));
        status.pos_end   = (cnt >= {1'b0, len_reg}) || (cnt == 33'(TAB_POSITIONS));
        status.bs_ge_len = (bytes_seen_reg >= len_reg);
        status.pair_done = (pdiff[2:0] == 3'd7) && pdiff[3];
        status.out_busy  = out_valid_reg && !out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_hash  = hash_reg;

endmodule

FILE: rtl/tbh64_ctrl.sv
// ----------------------------------------------------------------------------
// tbh64_ctrl
// sequencer for table writes, per-byte steps, scramble, mix and finalize
// ----------------------------------------------------------------------------
module tbh64_ctrl
    import tbh64_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t     state_reg, state_next;
    state_t     ret_reg, ret_next;
    prime_t     prime_reg, prime_next;
    logic [5:0] upc_reg, upc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            prime_reg <= PR_A;
            upc_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            prime_reg <= prime_next;
            upc_reg   <= upc_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        prime_next = prime_reg;
        upc_next   = upc_reg;
        cmd.op     = OP_NONE;
        cmd.prime  = prime_reg;
        cmd.upc    = upc_reg;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LATCH;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (status.kind == KIND_EMPTY || (status.kind == KIND_BYTE && status.len_zero))
                begin
                    state_next = ST_E_RD;
                end
                else if (status.kind == KIND_BYTE)
                begin
                    if (status.bs_zero)
                    begin
                        state_next = ST_S_RD;
                    end
                    else if (status.bs_lt_tp)
                    begin
                        state_next = ST_P_RD;
                    end
                    else
                    begin
                        state_next = ST_GATHER;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            // empty key
            ST_E_RD:
            begin
                cmd.op     = OP_RD_0;
                state_next = ST_E_LOAD;
            end
            ST_E_LOAD:
            begin
                cmd.op     = OP_V_EMPTY;
                state_next = ST_XS_PRE;
                prime_next = PR_A;
                ret_next   = ST_E_INC;
            end
            ST_E_INC:
            begin
                cmd.op     = OP_V_INC;
                state_next = ST_XS_PRE;
                prime_next = PR_B;
                ret_next   = ST_OUT_V;
            end
            // first byte seeds lane c
            ST_S_RD:
            begin
                cmd.op     = OP_RD_0;
                state_next = ST_S_LOAD;
            end
            ST_S_LOAD:
            begin
                cmd.op     = OP_V_SEED;
                state_next = ST_XS_PRE;
                prime_next = PR_A;
                ret_next   = ST_S_SET;
            end
            ST_S_SET:
            begin
                cmd.op     = OP_C_FROM_V;
                state_next = ST_P_RD;
            end
            ST_P_RD:
            begin
                cmd.op     = OP_RD_POS;
                state_next = ST_P_XOR;
            end
            ST_P_XOR:
            begin
                cmd.op     = OP_XOR_POS;
                state_next = status.pos_end ? ST_P_FIN : ST_IDLE;
            end
            ST_P_FIN:
            begin
                cmd.op     = OP_V_C_LEN1;
                state_next = ST_XS_PRE;
                prime_next = PR_B;
                ret_next   = ST_P_DONE;
            end
            ST_P_DONE:
            begin
                if (status.bs_ge_len)
                begin
                    state_next = ST_OUT_V;
                end
                else
                begin
                    cmd.op     = OP_C_FROM_V;
                    state_next = ST_T1_RD;
                end
            end
            // set up the three mix lanes
            ST_T1_RD:
            begin
                cmd.op     = OP_RD_1;
                state_next = ST_T1_LOAD;
            end
            ST_T1_LOAD:
            begin
                cmd.op     = OP_V_T1;
                state_next = ST_XS_PRE;
                prime_next = PR_A;
                ret_next   = ST_B_SET;
            end
            ST_B_SET:
            begin
                cmd.op     = OP_B_FROM_V;
                state_next = ST_C3;
            end
            ST_C3:
            begin
                cmd.op     = OP_V_C_LEN3;
                state_next = ST_XS_PRE;
                prime_next = PR_C;
                ret_next   = ST_C_SET;
            end
            ST_C_SET:
            begin
                cmd.op     = OP_C_FROM_V;
                state_next = ST_T2_RD;
            end
            ST_T2_RD:
            begin
                cmd.op     = OP_RD_2;
                state_next = ST_A_SET;
            end
            ST_A_SET:
            begin
                cmd.op     = OP_A_FROM_RD;
                state_next = ST_IDLE;
            end
            // bytes past the table positions
            ST_GATHER:
            begin
                cmd.op = OP_GATHER;
                if (status.pair_done)
                begin
                    upc_next   = MIX_FIRST;
                    state_next = ST_MIX;
                end
                else
                begin
                    state_next = ST_TAIL_CHK;
                end
            end
            ST_MIX:
            begin
                cmd.op   = OP_MICRO;
                upc_next = upc_reg + 6'd1;
                if (upc_reg == MIX_LAST)
                begin
                    state_next = ST_TAIL_CHK;
                end
            end
            ST_TAIL_CHK:
            begin
                state_next = status.bs_ge_len ? ST_TAIL : ST_IDLE;
            end
            ST_TAIL:
            begin
                cmd.op     = OP_TAIL;
                upc_next   = FIN_FIRST;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                cmd.op   = OP_MICRO;
                upc_next = upc_reg + 6'd1;
                if (upc_reg == FIN_LAST)
                begin
                    state_next = ST_OUT_F;
                end
            end
            // hold here while the previous result is still waiting
            ST_OUT_V:
            begin
                if (!status.out_busy)
                begin
                    cmd.op     = OP_OUT_V;
                    state_next = ST_IDLE;
                end
            end
            ST_OUT_F:
            begin
                if (!status.out_busy)
                begin
                    cmd.op     = OP_OUT_FIN;
                    state_next = ST_IDLE;
                end
            end
            // shared scramble sequence, returns to ret_reg
            ST_XS_PRE:
            begin
                cmd.op     = OP_XS_PRE;
                state_next = ST_MUL_LL;
            end
            ST_MUL_LL:
            begin
                cmd.op     = OP_MUL_LL;
                state_next = ST_MUL_LH;
            end
            ST_MUL_LH:
            begin
                cmd.op     = OP_MUL_LH;
                state_next = ST_MUL_HL;
            end
            ST_MUL_HL:
            begin
                cmd.op     = OP_MUL_HL;
                state_next = ST_XS_POST;
            end
            ST_XS_POST:
            begin
                cmd.op     = OP_XS_POST;
                state_next = ret_reg;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/tabulation_byte_hash64.sv
// ----------------------------------------------------------------------------
// tabulation_byte_hash64
// keyed 64-bit tabulation hash over a byte stream, table loaded by beats
// ----------------------------------------------------------------------------
// channel    dir  payload
// s_axis     in   tdata: table_index, table_word, key_byte, key_length; tuser: kind
// m_axis     out  tdata: hash_value
//
// a table write beat is latched, then dispatched; a byte inside the table positions
// xors its entry into lane c, the first byte of a key first seeding lane c by a
// scramble (xorshift, three 32x32 partial products, xorshift); bytes past the positions
// read no entry, mixed every 16 bytes; key end adds scrambles or the finalize chain
// reset clears all key state; the table is undefined until written
// a result still waiting when the next one is due stalls the sequencer and the input
module tabulation_byte_hash64
    import tbh64_pkg::*;
#(
    parameter int TAB_POSITIONS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [TDATA_W-1:0] s_axis_tdata,  // table_index, table_word, key_byte, key_length
    input  logic [1:0]         s_axis_tuser,  // kind
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [63:0]        m_axis_tdata   // hash_value
);

    cmd_t    cmd;
    status_t status;

    tbh64_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tbh64_datapath #(
        .TAB_POSITIONS (TAB_POSITIONS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (s_axis_tdata),
        .in_kind   (s_axis_tuser),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_hash  (m_axis_tdata)
    );

`include "tabulation_byte_hash64_macros.svh"

    `TBH_ASSERT_NEXT(a_one_beat_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while busy")
    `TBH_ASSERT_NOW(a_no_overwrite, cmd.op == OP_OUT_V || cmd.op == OP_OUT_FIN, !(m_axis_tvalid && !m_axis_tready), "result overwritten")
    `TBH_ASSERT_NOW(a_valid_from_load, $rose(m_axis_tvalid), $past(cmd.op) == OP_OUT_V || $past(cmd.op) == OP_OUT_FIN, "result without load")

endmodule
